[hw/rtl/ihrl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ihrl_pkg
// Shared types and constants for the Intel HEX record loader.
// ---------------------------------------------------------------------------
package ihrl_pkg;

	localparam int CHAR_W     = 8;
	localparam int ADDR_W     = 16;
	localparam int REC_ADDR_W = 17;   // record address, one bit of headroom
	localparam int LEN_W      = 17;
	localparam int KIND_W     = 2;
	localparam int ERR_W      = 3;
	localparam int BYTE_W     = 8;
	localparam int TDATA_W    = 72;   // 68 bits of fields, padded to bytes

	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_START = 3'd1,
		ERR_BAD_DIGIT = 3'd2,
		ERR_BAD_TYPE  = 3'd3,
		ERR_CHECKSUM  = 3'd4,
		ERR_ADDR_OVF  = 3'd5,
		ERR_TRUNCATED = 3'd6
	} err_t;

	typedef enum logic [6:0] {
		PH_FIRST   = 7'b0000001,
		PH_BETWEEN = 7'b0000010,
		PH_COUNT   = 7'b0000100,
		PH_ADDR    = 7'b0001000,
		PH_TYPE    = 7'b0010000,
		PH_DATA    = 7'b0100000,
		PH_CSUM    = 7'b1000000
	} phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  write_addr;
		logic [BYTE_W-1:0]  write_data;
		logic [ADDR_W-1:0]  image_start;
		logic [LEN_W-1:0]   image_length;
		err_t               error_code;
		logic [BYTE_W-1:0]  computed_checksum;
	} result_t;

	// hex digit decode: bit 4 set when the character is a valid digit
	function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/intel_hex_record_loader_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// intel_hex_record_loader_unit
// Streaming Intel HEX parser: characters in, memory writes / summary out.
// ---------------------------------------------------------------------------
// One ASCII character enters per word on the slave stream and one character
// is parsed per cycle: sustained rate is one word per clock, and each
// accepted character is held in the input register, then the parser step
// loads its result into the output register. Only back-pressure on the
// master stream slows intake. Each data byte of a type 00/01 record yields a
// write word; a NUL between records yields a done word with the lowest
// address written and the image length (0 when no data was seen). Any error
// yields one error word and then the block goes silent until reset;
// characters keep being accepted and dropped. tuser carries the result kind.
module intel_hex_record_loader_unit #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [ihrl_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] ascii_char
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// [15:0] write_addr, [23:16] write_data, [39:24] image_start,
	// [56:40] image_length, [59:57] error_code, [67:60] computed_checksum,
	// [71:68] zero
	output logic [ihrl_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic [ihrl_pkg::KIND_W-1:0]       m_axis_tuser    // [1:0] result_kind
);
	import ihrl_pkg::*;

	// stage 1: registered character
	logic              vld_s1;
	logic [CHAR_W-1:0] ch_s1;
	// stage 2: result register
	logic              vld_s2;
	result_t           res_s2;

	logic    adv;        // stage 1 character is parsed this cycle
	logic    res_valid;
	result_t res;

	// parse when the result register is free or being drained
	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	ihrl_parser #(
		.ADDR_BITS(ADDR_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.ch       (ch_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= res_valid;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {4'b0000,
		res_s2.computed_checksum,
		res_s2.error_code,
		res_s2.image_length,
		res_s2.image_start,
		res_s2.write_data,
		res_s2.write_addr};

endmodule
`default_nettype wire

[hw/rtl/ihrl_parser.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ihrl_parser
// Record parser state and the one-character update step.
// ---------------------------------------------------------------------------
module ihrl_parser #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [ihrl_pkg::CHAR_W-1:0] ch,
	output logic                            res_valid,
	output ihrl_pkg::result_t               res
);
	import ihrl_pkg::*;

	phase_t                  phase_q, phase_d;
	logic [1:0]              nib_q, nib_d;
	logic [ADDR_W-1:0]       fv_q, fv_d;
	logic [BYTE_W-1:0]       left_q, left_d;
	logic [REC_ADDR_W-1:0]   raddr_q, raddr_d;
	logic [BYTE_W-1:0]       sum_q, sum_d;
	logic [ADDR_W-1:0]       low_q, low_d;
	logic [ADDR_W-1:0]       high_q, high_d;
	logic                    seen_q, seen_d;
	logic                    err_q, err_d;

	logic [4:0]              hd;
	logic [ADDR_W-1:0]       fv_new;
	logic [2:0]              nib_inc;
	logic                    field_done;
	logic [BYTE_W-1:0]       comp;
	logic [BYTE_W-1:0]       left_dec;

	assign hd       = hex_decode(ch);
	assign fv_new   = {fv_q[ADDR_W-5:0], hd[3:0]};
	assign nib_inc  = {1'b0, nib_q} + 3'd1;
	assign field_done = (phase_q == PH_ADDR) ? (nib_inc == 3'd4) : (nib_inc == 3'd2);
	assign comp     = 8'(9'h100 - {1'b0, sum_q});
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		nib_d   = nib_q;
		fv_d    = fv_q;
		left_d  = left_q;
		raddr_d = raddr_q;
		sum_d   = sum_q;
		low_d   = low_q;
		high_d  = high_q;
		seen_d  = seen_q;
		err_d   = err_q;
		res_valid = 1'b0;
		res       = '0;

		if (!err_q) begin
			unique case (phase_q) inside
				PH_FIRST, PH_BETWEEN: begin
					if (ch == CH_COLON) begin
						phase_d = PH_COUNT;
						nib_d   = 2'd0;
						fv_d    = '0;
						sum_d   = '0;
					end else if (ch == CH_NUL) begin
						res_valid = 1'b1;
						res.kind  = KIND_DONE;
						if (seen_q) begin
							res.image_start  = low_q;
							res.image_length = {1'b0, high_q} - {1'b0, low_q} + 17'd1;
						end
					end else if (!(phase_q == PH_BETWEEN && (ch == CH_CR || ch == CH_LF))) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_START;
						err_d          = 1'b1;
					end
				end
				PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
					if (ch == CH_NUL) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_TRUNCATED;
						err_d          = 1'b1;
					end else if (!hd[4]) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_DIGIT;
						err_d          = 1'b1;
					end else if (!field_done) begin
						fv_d  = fv_new;
						nib_d = nib_inc[1:0];
					end else begin
						fv_d  = '0;
						nib_d = 2'd0;
						if (phase_q == PH_COUNT) begin
							left_d  = fv_new[7:0];
							sum_d   = sum_q + fv_new[7:0];
							phase_d = PH_ADDR;
						end else if (phase_q == PH_ADDR) begin
							raddr_d = {1'b0, fv_new};
							sum_d   = sum_q + fv_new[15:8] + fv_new[7:0];
							phase_d = PH_TYPE;
						end else if (phase_q == PH_TYPE) begin
							sum_d = sum_q + fv_new[7:0];
							if (fv_new[7:0] > 8'd1) begin
								res_valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_BAD_TYPE;
								err_d          = 1'b1;
							end else begin
								phase_d = (left_q != 8'd0) ? PH_DATA : PH_CSUM;
							end
						end else if (phase_q == PH_DATA) begin
							sum_d = sum_q + fv_new[7:0];
							if (raddr_q[REC_ADDR_W-1:ADDR_BITS] != '0) begin
								res_valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_ADDR_OVF;
								err_d          = 1'b1;
							end else begin
								res_valid      = 1'b1;
								res.kind       = KIND_WRITE;
								res.write_addr = raddr_q[ADDR_W-1:0];
								res.write_data = fv_new[7:0];
								if (raddr_q[ADDR_W-1:0] < low_q)  low_d  = raddr_q[ADDR_W-1:0];
								if (raddr_q[ADDR_W-1:0] > high_q) high_d = raddr_q[ADDR_W-1:0];
								seen_d  = 1'b1;
								raddr_d = raddr_q + 17'd1;
								left_d  = left_dec;
								if (left_dec == 8'd0) phase_d = PH_CSUM;
							end
						end else begin
							phase_d = PH_BETWEEN;
							if (fv_new[7:0] != comp) begin
								res_valid             = 1'b1;
								res.kind              = KIND_ERROR;
								res.error_code        = ERR_CHECKSUM;
								res.computed_checksum = comp;
								err_d                 = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			nib_q   <= '0;
			fv_q    <= '0;
			left_q  <= '0;
			raddr_q <= '0;
			sum_q   <= '0;
			low_q   <= '1;
			high_q  <= '0;
			seen_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			fv_q    <= fv_d;
			left_q  <= left_d;
			raddr_q <= raddr_d;
			sum_q   <= sum_d;
			low_q   <= low_d;
			high_q  <= high_d;
			seen_q  <= seen_d;
			err_q   <= err_d;
		end
	end

endmodule
`default_nettype wire
